FILE: sv/multipath_switch_policy_macros.svh
// Assertion helpers for the path switch policy.
`ifndef MULTIPATH_SWITCH_POLICY_MACROS_SVH
`define MULTIPATH_SWITCH_POLICY_MACROS_SVH

// Property must hold at every edge out of reset.
`define MSP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define MSP_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: sv/msp_pkg.sv
package msp_pkg;

	typedef struct packed {
		logic [31:0] report_time;
		logic [7:0]  loss;
		logic [31:0] alert_time;
		logic [31:0] echo_time;
		logic [31:0] share;
		logic [31:0] cand_since;
	} entry_t;

	localparam logic [1:0] REQ_REPORT = 2'd0;
	localparam logic [1:0] REQ_ECHO   = 2'd1;
	localparam logic [1:0] REQ_ALERT  = 2'd2;
	localparam logic [1:0] REQ_TICK   = 2'd3;

	localparam logic [2:0] ST_UPDATED   = 3'd0;
	localparam logic [2:0] ST_ECHO_IGN  = 3'd1;
	localparam logic [2:0] ST_WAIT_GAP  = 3'd2;
	localparam logic [2:0] ST_NO_CAND   = 3'd3;
	localparam logic [2:0] ST_STAYED    = 3'd4;
	localparam logic [2:0] ST_SWITCHED  = 3'd5;
	localparam logic [2:0] ST_DISABLED  = 3'd6;

	localparam logic [2:0] CFG_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_PATHS     = 3'd1;
	localparam logic [2:0] CFG_MARGIN    = 3'd2;
	localparam logic [2:0] CFG_ALIVE     = 3'd3;
	localparam logic [2:0] CFG_ALERT     = 3'd4;
	localparam logic [2:0] CFG_GAP       = 3'd5;
	localparam logic [2:0] CFG_CANDIDACY = 3'd6;
	localparam logic [2:0] CFG_LOSS      = 3'd7;

	localparam logic [31:0] SETTLE_MS = 32'd100;

	localparam logic [5:0] DIV_ITERS_SHARE = 6'd48;
	localparam logic [5:0] DIV_ITERS_PICK  = 6'd16;

endpackage

FILE: sv/multipath_switch_policy.sv
// Item flow: an item that stores nothing (empty echo, disabled tick, index beyond the
// table) is answered straight from idle; report, alert and echo read, then write their
// entry, an echo with the flow-count correction first multiplies and divides, and a
// tick reads the current entry, walks the paths and divides when a pick is made.
// Throughput: one item at a time, a new item is taken only once the last result is
// taken; the table walk and the shared bit-serial divider set how long an item holds.
// Reset: asynchronous, clears control state and per-entry valid bits at once.
module multipath_switch_policy #(
	parameter int MAX_PATHS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [2:0]  path_index,
	input  logic [31:0] now_ms,
	input  logic [7:0]  loss_q8,
	input  logic [31:0] share_kbps,
	input  logic [15:0] flow_count,
	input  logic        echo_empty,
	input  logic [31:0] target_kbps,
	input  logic [15:0] random_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [2:0]  cur_path,
	output logic [2:0]  last_path,
	output logic [3:0]  candidate_count,
	output logic        active_usable,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "multipath_switch_policy_macros.svh"

	localparam int IW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EV_RD   = 4'd1;
	localparam logic [3:0] S_EV_WR   = 4'd2;
	localparam logic [3:0] S_MUL     = 4'd3;
	localparam logic [3:0] S_DIV_GO  = 4'd4;
	localparam logic [3:0] S_DIV     = 4'd5;
	localparam logic [3:0] S_T_RDCUR = 4'd6;
	localparam logic [3:0] S_T_CUR   = 4'd7;
	localparam logic [3:0] S_T_RD    = 4'd8;
	localparam logic [3:0] S_T_EVAL  = 4'd9;
	localparam logic [3:0] S_T_DEC   = 4'd10;
	localparam logic [3:0] S_T_PICK  = 4'd11;

	// configuration
	logic        enable_q;
	logic [3:0]  paths_q;
	logic [7:0]  margin_q;
	logic [15:0] alive_q;
	logic [15:0] hold_q;
	logic [15:0] gap_q;
	logic [15:0] candq_q;
	logic [7:0]  losslim_q;

	// control state
	logic [3:0]           st_q;
	logic [2:0]           cur_q;
	logic [2:0]           prior_q;
	logic [31:0]          lct_q;
	logic [MAX_PATHS-1:0] vld_q;
	logic [MAX_PATHS-1:0] cflag_q;
	logic                 usable_q;
	logic [3:0]           wi_q;
	logic [3:0]           cnt_q;
	logic [IW-1:0]        fin_q [16];

	// item registers
	logic [1:0]  req_q;
	logic [2:0]  p_q;
	logic [31:0] now_q;
	logic [7:0]  loss_q;
	logic [31:0] share_q;
	logic [15:0] flows_q;
	logic [31:0] tgt_q;
	logic [15:0] rnd_q;
	logic [47:0] prod_q;
	logic [39:0] tgtm_q;
	logic [31:0] chg_q;

	// result register
	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [2:0]  act_q;
	logic [2:0]  prev_q;
	logic [3:0]  count_q;
	logic        use_q;

	// table memory
	msp_pkg::entry_t mem [MAX_PATHS];
	msp_pkg::entry_t rd_q;
	logic            rdv_q;
	msp_pkg::entry_t ent;
	msp_pkg::entry_t wd;
	logic [IW-1:0]   ra;
	logic [IW-1:0]   wa;
	logic            we;

	// divider
	logic        div_go;
	logic [47:0] div_dvd;
	logic [15:0] div_dsor;
	logic [5:0]  div_iters;
	logic        div_busy;
	logic        div_done;
	logic [47:0] div_quo;
	logic [15:0] div_rem;

	logic        acc;
	logic [3:0]  n_c;
	logic        p_in_tab;
	logic        cur_in_tab;
	logic        corr_c;
	logic        is_cur;
	logic        excl;
	logic [31:0] since_c;
	logic        final_c;
	logic [IW-1:0] pick;
	logic [IW-1:0] wi_idx;
	logic        gap_wait;

	assign acc        = req_valid && !req_stall;
	assign req_stall  = (st_q != S_IDLE) || rsp_valid_q;
	assign cfg_ready  = 1'b1;
	assign n_c        = (32'(paths_q) < MAX_PATHS) ? paths_q : 4'(MAX_PATHS);
	assign p_in_tab   = 32'(path_index) < MAX_PATHS;
	assign cur_in_tab = 32'(cur_q) < MAX_PATHS;
	assign corr_c     = (path_index == cur_q) && (flow_count > 16'd1)
		&& ((now_ms - lct_q) > msp_pkg::SETTLE_MS);
	assign wi_idx     = IW'(wi_q);
	assign ent        = rdv_q ? rd_q : '0;
	assign is_cur     = (32'(wi_q) == 32'(cur_q)) && usable_q;
	assign excl       = ((now_q - ent.alert_time) < {16'd0, hold_q})
		|| !((now_q - ent.echo_time) < chg_q)
		|| (usable_q && ({4'd0, ent.share, 4'd0} < tgtm_q));
	assign since_c    = cflag_q[wi_idx] ? ent.cand_since : now_q;
	assign final_c    = (now_q - since_c) >= {16'd0, candq_q};
	assign pick       = fin_q[div_rem[3:0]];
	assign gap_wait   = usable_q && (chg_q < {16'd0, gap_q});

	always_comb begin
		priority if (st_q == S_T_RD) begin
			ra = wi_idx;
		end else if (st_q == S_T_RDCUR) begin
			ra = IW'(cur_q);
		end else begin
			ra = IW'(p_q);
		end
	end

	always_comb begin
		wd = ent;
		wa = IW'(p_q);
		we = 1'b0;
		if (st_q == S_EV_WR) begin
			we = 1'b1;
			unique case (req_q)
				msp_pkg::REQ_REPORT: begin
					wd.report_time = now_q;
					wd.loss        = loss_q;
				end
				msp_pkg::REQ_ECHO: begin
					wd.echo_time = now_q;
					wd.share     = share_q;
				end
				msp_pkg::REQ_ALERT: wd.alert_time = now_q;
				default: we = 1'b0;
			endcase
		end else if (st_q == S_T_EVAL) begin
			wa            = wi_idx;
			wd.cand_since = now_q;
			we            = !is_cur && !excl && !cflag_q[wi_idx];
		end
	end

	// an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q  <= mem[ra];
		rdv_q <= vld_q[ra];
	end

	always_comb begin
		div_go    = 1'b0;
		div_dvd   = prod_q;
		div_dsor  = flows_q - 16'd1;
		div_iters = msp_pkg::DIV_ITERS_SHARE;
		if (st_q == S_DIV_GO) begin
			div_go = 1'b1;
		end else if (st_q == S_T_DEC && !gap_wait && cnt_q != 4'd0) begin
			div_go    = 1'b1;
			div_dvd   = {rnd_q, 32'd0};
			div_dsor  = {12'd0, cnt_q};
			div_iters = msp_pkg::DIV_ITERS_PICK;
		end
	end

	msp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dvd),
		.divisor   (div_dsor),
		.iters     (div_iters),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			paths_q   <= 4'd8;
			margin_q  <= 8'd24;
			alive_q   <= 16'd1000;
			hold_q    <= 16'd1000;
			gap_q     <= 16'd2000;
			candq_q   <= 16'd1000;
			losslim_q <= 8'd192;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msp_pkg::CFG_ENABLE:    enable_q  <= cfg_data[0];
				msp_pkg::CFG_PATHS:     paths_q   <= cfg_data[3:0];
				msp_pkg::CFG_MARGIN:    margin_q  <= cfg_data[7:0];
				msp_pkg::CFG_ALIVE:     alive_q   <= cfg_data[15:0];
				msp_pkg::CFG_ALERT:     hold_q    <= cfg_data[15:0];
				msp_pkg::CFG_GAP:       gap_q     <= cfg_data[15:0];
				msp_pkg::CFG_CANDIDACY: candq_q   <= cfg_data[15:0];
				msp_pkg::CFG_LOSS:      losslim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q   <= req_type;
			p_q     <= path_index;
			now_q   <= now_ms;
			loss_q  <= loss_q8;
			share_q <= share_kbps;
			flows_q <= flow_count;
			tgt_q   <= target_kbps;
			rnd_q   <= random_value;
		end
		if (st_q == S_MUL) begin
			prod_q <= share_q * {32'd0, flows_q};
		end
		if (st_q == S_DIV && div_done && req_q == msp_pkg::REQ_ECHO) begin
			share_q <= (div_quo[47:32] != 16'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
		end
		if (st_q == S_T_RDCUR) begin
			tgtm_q <= tgt_q * {24'd0, margin_q};
			chg_q  <= now_q - lct_q;
		end
		if (st_q == S_T_EVAL && (is_cur || (!excl && final_c))) begin
			fin_q[cnt_q] <= wi_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cur_q       <= '0;
			prior_q     <= '0;
			lct_q       <= '0;
			vld_q       <= '0;
			cflag_q     <= '0;
			usable_q    <= 1'b0;
			wi_q        <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= '0;
			act_q       <= '0;
			prev_q      <= '0;
			count_q     <= '0;
			use_q       <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						status_q <= msp_pkg::ST_UPDATED;
						act_q    <= cur_q;
						prev_q   <= prior_q;
						count_q  <= '0;
						use_q    <= 1'b0;
						unique case (req_type)
							msp_pkg::REQ_REPORT, msp_pkg::REQ_ALERT: begin
								if (p_in_tab) begin
									st_q <= S_EV_RD;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							msp_pkg::REQ_ECHO: begin
								priority if (echo_empty) begin
									status_q    <= msp_pkg::ST_ECHO_IGN;
									rsp_valid_q <= 1'b1;
								end else if (!p_in_tab) begin
									rsp_valid_q <= 1'b1;
								end else if (corr_c) begin
									st_q <= S_MUL;
								end else begin
									st_q <= S_EV_RD;
								end
							end
							default: begin
								if (enable_q) begin
									st_q <= S_T_RDCUR;
								end else begin
									status_q    <= msp_pkg::ST_DISABLED;
									rsp_valid_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_EV_RD:  st_q <= S_EV_WR;
				S_EV_WR: begin
					rsp_valid_q <= 1'b1;
					st_q        <= S_IDLE;
				end
				S_MUL:    st_q <= S_DIV_GO;
				S_DIV_GO: st_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						st_q <= (req_q == msp_pkg::REQ_TICK) ? S_T_PICK : S_EV_RD;
					end
				end
				S_T_RDCUR: st_q <= S_T_CUR;
				S_T_CUR: begin
					usable_q <= cur_in_tab
						&& ((now_q - ent.report_time) < {16'd0, alive_q})
						&& (ent.loss < losslim_q)
						&& ((now_q - ent.alert_time) > {16'd0, hold_q});
					wi_q  <= '0;
					cnt_q <= '0;
					st_q  <= (n_c == 4'd0) ? S_T_DEC : S_T_RD;
				end
				S_T_RD: st_q <= S_T_EVAL;
				S_T_EVAL: begin
					if (!is_cur) begin
						cflag_q[wi_idx] <= !excl;
					end
					if (is_cur || (!excl && final_c)) begin
						cnt_q <= cnt_q + 4'd1;
					end
					wi_q <= wi_q + 4'd1;
					st_q <= (wi_q + 4'd1 == n_c) ? S_T_DEC : S_T_RD;
				end
				S_T_DEC: begin
					count_q <= cnt_q;
					use_q   <= usable_q;
					priority if (gap_wait) begin
						status_q    <= msp_pkg::ST_WAIT_GAP;
						rsp_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end else if (cnt_q == 4'd0) begin
						status_q    <= msp_pkg::ST_NO_CAND;
						rsp_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_T_PICK: begin
					lct_q       <= now_q;
					rsp_valid_q <= 1'b1;
					st_q        <= S_IDLE;
					if (32'(pick) == 32'(cur_q)) begin
						status_q <= msp_pkg::ST_STAYED;
					end else begin
						status_q <= msp_pkg::ST_SWITCHED;
						prior_q  <= cur_q;
						cur_q    <= 3'(pick);
						act_q    <= 3'(pick);
						prev_q   <= cur_q;
						// drop candidacy of every walked entry
						for (int j = 0; j < MAX_PATHS; j++) begin
							if (j < 32'(n_c)) begin
								cflag_q[j] <= 1'b0;
							end
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign cur_path        = act_q;
	assign last_path       = prev_q;
	assign candidate_count = count_q;
	assign active_usable   = use_q;

	`MSP_ASSERT(a_rsp_only_idle, rsp_valid |-> st_q == S_IDLE, "result pending while busy")
	`MSP_ASSERT(a_accept_leaves_idle, (acc && !(req_type == msp_pkg::REQ_ECHO && echo_empty)
		&& !(req_type == msp_pkg::REQ_TICK && !enable_q) && p_in_tab) |=> st_q != S_IDLE,
		"accepted item not started")
	`MSP_NEVER(a_div_restart, div_go && div_busy, "divider restarted while busy")

endmodule

FILE: sv/msp_div.sv
module msp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] dividend,
	input  logic [15:0] divisor,
	input  logic [5:0]  iters,
	output logic        busy,
	output logic        done,
	output logic [47:0] quotient,
	output logic [15:0] remainder
);

	logic [47:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] dsor_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        ge;

	assign trial = {rem_q, dvd_q[47]};
	assign ge    = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 16'(trial - {1'b0, dsor_q}) : trial[15:0];
			dvd_q <= {dvd_q[46:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule
